[rtl/keyframe_translation_track_unit_assert.svh]
// Assertion macros for the keyframe translation track unit
`ifndef KEYFRAME_TRANSLATION_TRACK_UNIT_ASSERT_SVH
`define KEYFRAME_TRANSLATION_TRACK_UNIT_ASSERT_SVH

// same-cycle implication
`define KFT_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("kft assertion failed");

// next-cycle implication
`define KFT_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("kft assertion failed");

`endif

[rtl/kft_pkg.sv]
// Shared types and codes for the keyframe translation track unit
package kft_pkg;

    typedef logic signed [31:0] coord_t;
    typedef coord_t [2:0] point_t;

    localparam int FRAC_W = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

endpackage

[rtl/kft_cell.sv]
// One keyframe slot of the sorted chain
module kft_cell
    import kft_pkg::*;
(
    input  logic   clk,
    input  logic   valid,
    input  coord_t key,
    input  point_t pt_new,
    input  logic   ins_en,
    input  logic   ow_en,
    input  logic   left_pass,
    input  coord_t left_time,
    input  point_t left_pt,
    output coord_t time_q,
    output point_t pt_q,
    output logic   gt,
    output logic   eq,
    output logic   pass
);

    coord_t time_reg;
    point_t pt_reg;

    assign gt     = valid && (time_reg > key);
    assign eq     = valid && (time_reg == key);
    assign pass   = !valid || gt;
    assign time_q = time_reg;
    assign pt_q   = pt_reg;

    always_ff @(posedge clk)
    begin
        if (ins_en && pass)
        begin
            if (left_pass)
            begin
                time_reg <= left_time;
                pt_reg   <= left_pt;
            end
            else
            begin
                time_reg <= key;
                pt_reg   <= pt_new;
            end
        end
        else if (ow_en && eq)
        begin
            pt_reg <= pt_new;
        end
    end

endmodule

[rtl/kft_div.sv]
// Restoring divider for the 16-bit interpolation fraction
module kft_div
    import kft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [32:0]       num,
    input  logic [32:0]       den,
    output logic              done,
    output logic [FRAC_W-1:0] quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [32:0]       rem_reg;
    logic [32:0]       den_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [33:0]       rem2;
    logic              take;

    assign rem2 = {rem_reg, 1'b0};
    assign take = rem2 >= {1'b0, den_reg};
    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? 33'(rem2 - {1'b0, den_reg}) : rem2[32:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], take};
        end
    end

endmodule

[rtl/keyframe_translation_track_unit.sv]
// Keyframe translation track: sorted keyframe chain with linear interpolation
//
// Input channel (in_valid/in_ready): opcode 0 inserts a keyframe at key_time
// with point (point_x, point_y, point_z); opcode 1 queries the track at key_time.
// Output channel (out_valid/out_ready): one result per input transfer, in order,
// carrying the point (zero for inserts), stored_keys and status.
// One item at a time. Insert, empty query and clamped query pass through the
// evaluate state to the output register; an interpolated query also passes
// the 16-step fraction divider, then one multiply and one add stage.
// All keyframe slots compare against the key in parallel; an insert shifts
// later keys one slot along the chain all together.
// Reset empties the track (count to zero); slot contents need no clearing.
// When the receiver stalls, the result holds in the output register and the
// unit waits before finishing the next item.
module keyframe_translation_track_unit
    import kft_pkg::*;
#(
    parameter int MAX_KEYS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         opcode,
    input  coord_t       key_time,
    input  coord_t       point_x,
    input  coord_t       point_y,
    input  coord_t       point_z,
    output logic         out_valid,
    input  logic         out_ready,
    output coord_t       out_x,
    output coord_t       out_y,
    output coord_t       out_z,
    output logic [6:0]   stored_keys,
    output logic [1:0]   status
);

    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          op_reg;
    coord_t        key_reg;
    point_t        pt_reg;

    logic          out_valid_reg, out_valid_next;
    point_t        out_pt_reg;
    logic [1:0]    status_reg;
    logic          out_load;
    point_t        out_pt_next;
    logic [1:0]    status_next;

    coord_t             time_c [MAX_KEYS];
    point_t             pt_c   [MAX_KEYS];
    logic [MAX_KEYS-1:0] gt, eq, pass, valid, last, hi_sel, lo_sel;

    logic          ins_en, ow_en, any_gt, any_eq, full, direct, out_ok;
    coord_t        t0_sel, t1_sel;
    point_t        p0_sel, p1_sel;

    point_t        p0_reg;
    logic signed [32:0] diff_reg [3];
    logic signed [49:0] prod_reg [3];
    logic [FRAC_W-1:0]  frac_reg;
    logic               div_start, div_done;
    logic [FRAC_W-1:0]  div_quo;
    logic [32:0]        div_num, div_den;

    genvar g;
    generate
        for (g = 0; g < MAX_KEYS; g++)
        begin : g_cell
            assign valid[g] = CW'(g) < count_reg;
            if (g == 0)
            begin : g_first
                kft_cell u_cell (
                    .clk(clk), .valid(valid[g]), .key(key_reg), .pt_new(pt_reg),
                    .ins_en(ins_en), .ow_en(ow_en), .left_pass(1'b0),
                    .left_time(key_reg), .left_pt(pt_reg),
                    .time_q(time_c[g]), .pt_q(pt_c[g]),
                    .gt(gt[g]), .eq(eq[g]), .pass(pass[g])
                );
                assign hi_sel[g] = gt[g];
            end
            else
            begin : g_rest
                kft_cell u_cell (
                    .clk(clk), .valid(valid[g]), .key(key_reg), .pt_new(pt_reg),
                    .ins_en(ins_en), .ow_en(ow_en), .left_pass(pass[g-1]),
                    .left_time(time_c[g-1]), .left_pt(pt_c[g-1]),
                    .time_q(time_c[g]), .pt_q(pt_c[g]),
                    .gt(gt[g]), .eq(eq[g]), .pass(pass[g])
                );
                assign hi_sel[g] = gt[g] && !gt[g-1];
            end
            if (g == MAX_KEYS - 1)
            begin : g_end
                assign last[g] = valid[g];
                assign lo_sel[g] = any_gt ? (gt[0] ? (g == 0) : 1'b0) : last[g];
            end
            else
            begin : g_mid
                assign last[g] = valid[g] && !valid[g+1];
                assign lo_sel[g] = any_gt ? (gt[0] ? (g == 0) : hi_sel[g+1]) : last[g];
            end
        end
    endgenerate

    assign any_gt = |gt;
    assign any_eq = |eq;
    assign full   = count_reg == CW'(MAX_KEYS);
    assign direct = !any_gt || gt[0];

    always_comb
    begin
        t0_sel = '0;
        t1_sel = '0;
        p0_sel = '0;
        p1_sel = '0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if (lo_sel[i])
            begin
                t0_sel = t0_sel | time_c[i];
                p0_sel = p0_sel | pt_c[i];
            end
            if (hi_sel[i])
            begin
                t1_sel = t1_sel | time_c[i];
                p1_sel = p1_sel | pt_c[i];
            end
        end
    end

    assign div_num = 33'({key_reg[31], key_reg} - {t0_sel[31], t0_sel});
    assign div_den = 33'({t1_sel[31], t1_sel} - {t0_sel[31], t0_sel});

    kft_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    assign out_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ins_en      = 1'b0;
        ow_en       = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        out_pt_next = '0;
        status_next = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (out_ok)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                        if (any_eq)
                            ow_en = 1'b1;
                        else if (full)
                            status_next = ST_REJECT;
                        else
                        begin
                            ins_en     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                else if (count_reg == '0)
                begin
                    if (out_ok)
                    begin
                        out_load    = 1'b1;
                        status_next = ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                end
                else if (direct)
                begin
                    if (out_ok)
                    begin
                        out_load    = 1'b1;
                        out_pt_next = p0_sel;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (out_ok)
                begin
                    out_load = 1'b1;
                    for (int k = 0; k < 3; k++)
                        out_pt_next[k] = p0_reg[k] + prod_reg[k][47:16];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode;
            key_reg <= key_time;
            pt_reg  <= {point_z, point_y, point_x};
        end
        if (div_start)
        begin
            p0_reg <= p0_sel;
            for (int k = 0; k < 3; k++)
                diff_reg[k] <= {p1_sel[k][31], p1_sel[k]} - {p0_sel[k][31], p0_sel[k]};
        end
        if (div_done)
            frac_reg <= div_quo;
        if (state_reg == S_MUL)
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= $signed({1'b0, frac_reg}) * diff_reg[k];
        end
        if (out_load)
        begin
            out_pt_reg <= out_pt_next;
            status_reg <= status_next;
        end
    end

    assign in_ready    = state_reg == S_IDLE;
    assign out_valid   = out_valid_reg;
    assign out_x       = out_pt_reg[0];
    assign out_y       = out_pt_reg[1];
    assign out_z       = out_pt_reg[2];
    assign status      = status_reg;
    assign stored_keys = 7'(count_reg);

endmodule

[rtl/kft_checker.sv]
// Port-level checker for the keyframe translation track unit
`include "keyframe_translation_track_unit_assert.svh"

module kft_checker
    import kft_pkg::*;
#(
    parameter int MAX_KEYS = 64
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input coord_t     out_x,
    input coord_t     out_y,
    input coord_t     out_z,
    input logic [6:0] stored_keys,
    input logic [1:0] status
);

    `KFT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
    `KFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
    `KFT_ASSERT_NOW(a_status_code, out_valid, status <= ST_REJECT)
    `KFT_ASSERT_NOW(a_empty_zero, out_valid && status == ST_EMPTY, {out_x, out_y, out_z, stored_keys} == '0)
    `KFT_ASSERT_NOW(a_reject_full, out_valid && status == ST_REJECT, stored_keys == 7'(MAX_KEYS) && out_x == 0)

endmodule

bind keyframe_translation_track_unit kft_checker #(.MAX_KEYS(MAX_KEYS)) u_kft_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .stored_keys(stored_keys), .status(status)
);
